// ----- rtl/nns_pkg.sv -----
// Shared constants for the nearest neighbor search unit.
`timescale 1ns / 1ps
`default_nettype none

package nns_pkg;

  localparam int COEFF_BITS = 16;
  localparam int IDX_W      = 6;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int DIST_W     = 38;
  localparam int FRAC_BITS  = 32;
  localparam int CONF_W     = 25;
  localparam int SQ_W       = 2 * COEFF_BITS + 1;
  localparam int DQ_W       = DIST_W + FRAC_BITS;
  localparam int RT_W       = DQ_W / 2;
  localparam int SR_W       = RT_W + 2;
  localparam int CNT_W      = $clog2(DQ_W);
  localparam int DEN_K_W    = 16;

  localparam logic [DIST_W-1:0]  DIST_MAX = '1;
  localparam logic [DEN_K_W-1:0] DEN_K    = 16'd65025;
  localparam int                 CONF_ONE = 65536;

  localparam logic OP_REF   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFS  = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/nearest_neighbour_search_unit.sv -----
// Nearest neighbor search by squared Euclidean distance, with confidence.
//
//  channel  | ports                                             | dir
//  ---------+---------------------------------------------------+-----
//  in       | in_valid/in_ready, opcode, indexes, coeff_value   | in
//  out      | out_valid/out_ready, index, distance, confidence  | out
//  cfg      | cfg_we, cfg_index, cfg_wdata                      | in
//
// A coefficient write word is accepted whenever in_ready is high. The last query
// coefficient starts a search: a one-multiplier scan, a drain of the scan pipeline,
// a load, then bit-serial division and bit-serial square root, after which
// out_valid rises. in_ready is low for all of that and while a finished result
// waits for the output register to empty. Reset is synchronous; the coefficient
// memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbour_search_unit #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_COEFFS  = 64
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_opcode,
  input  wire [nns_pkg::IDX_W-1:0]             in_entry_index,
  input  wire [nns_pkg::IDX_W-1:0]             in_coeff_index,
  input  wire signed [nns_pkg::COEFF_BITS-1:0] in_coeff_value,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [nns_pkg::IDX_W-1:0]            out_nearest_index,
  output logic [nns_pkg::DIST_W-1:0]           out_least_distance,
  output logic signed [nns_pkg::CONF_W-1:0]    out_confidence_q16,
  input  wire                                  cfg_we,
  input  wire [nns_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [nns_pkg::CFG_W-1:0]             cfg_wdata
);

  import nns_pkg::*;

  localparam int EW    = $clog2(MAX_ENTRIES);
  localparam int CW    = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int NE_W  = $clog2(MAX_ENTRIES + 1);
  localparam int NC_W  = $clog2(MAX_COEFFS + 1);
  localparam int DEPTH = MAX_ENTRIES * MAX_COEFFS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PROD_W = NE_W + NC_W;
  localparam longint unsigned DEN_MAX =
    longint'(MAX_ENTRIES) * longint'(MAX_COEFFS) * 64'd65025;
  localparam int DEN_W = $clog2(DEN_MAX + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_LOAD  = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_SQRT  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0] ent_cfg_r;
  logic [CFG_W-1:0] coef_cfg_r;
  logic [NE_W-1:0]  ne_cl;
  logic [NC_W-1:0]  nc_cl;
  logic [PROD_W-1:0] prod_r;
  logic [DEN_W-1:0]  den_r;

  logic signed [COEFF_BITS-1:0] ref_mem [0:DEPTH-1];
  logic signed [COEFF_BITS-1:0] q_mem [0:MAX_COEFFS-1];
  logic signed [COEFF_BITS-1:0] ref_rd_r;
  logic signed [COEFF_BITS-1:0] q_rd_r;

  logic          in_acc;
  logic          wr_ref;
  logic          wr_q;
  logic          start;
  logic [AW-1:0] ref_wa;
  logic [CW-1:0] q_wa;

  logic [EW-1:0] e_r;
  logic [CW-1:0] c_r;
  logic [AW-1:0] row_r;
  logic [AW-1:0] rd_addr;
  logic          c_last;
  logic          e_last;

  logic          s1_vld_r, s1_first_r, s1_last_r, s1_fin_r;
  logic [EW-1:0] s1_ent_r;
  logic          s2_vld_r, s2_first_r, s2_last_r, s2_fin_r;
  logic [EW-1:0] s2_ent_r;
  logic          s3_vld_r, s3_last_r, s3_fin_r;
  logic [EW-1:0] s3_ent_r;

  logic signed [COEFF_BITS:0]     diff;
  logic signed [2*COEFF_BITS+1:0] sq_full;
  logic [SQ_W-1:0]                sq_r;
  logic [DIST_W:0]                acc_sum;
  logic [DIST_W-1:0]              acc_r;
  logic [DIST_W-1:0]              acc_nxt;
  logic [DIST_W-1:0]              best_r;
  logic [EW-1:0]                  best_idx_r;

  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DQ_W-1:0]  dq_r;
  logic [DEN_W:0]   div_cand;
  logic             div_ge;
  logic [RT_W-1:0]  root_r;
  logic [SR_W-1:0]  srem_r;
  logic [SR_W+1:0]  sq_cand;
  logic [SR_W+1:0]  sq_trial;
  logic             sq_ge;
  logic [RT_W:0]    v_rnd;
  logic [RT_W+1:0]  conf_full;
  logic             out_load;

  // Register counts clamped to 1..max
  always_comb begin
    if (ent_cfg_r == '0) ne_cl = NE_W'(1);
    else if (32'(ent_cfg_r) > MAX_ENTRIES) ne_cl = NE_W'(MAX_ENTRIES);
    else ne_cl = NE_W'(ent_cfg_r);
    if (coef_cfg_r == '0) nc_cl = NC_W'(1);
    else if (32'(coef_cfg_r) > MAX_COEFFS) nc_cl = NC_W'(MAX_COEFFS);
    else nc_cl = NC_W'(coef_cfg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_cfg_r  <= CFG_W'(64);
      coef_cfg_r <= CFG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRIES: ent_cfg_r <= cfg_wdata;
        CFG_COEFFS:  coef_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Denominator E*C*65025; the user must keep config stable while busy, the block does not enforce it
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(ne_cl) * PROD_W'(nc_cl);
    den_r  <= DEN_W'(prod_r * DEN_K);
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wr_ref   = in_acc && (in_opcode == OP_REF) &&
                    (32'(in_entry_index) < MAX_ENTRIES) &&
                    (32'(in_coeff_index) < MAX_COEFFS);
  assign wr_q     = in_acc && (in_opcode == OP_QUERY) &&
                    (32'(in_coeff_index) < MAX_COEFFS);
  assign start    = wr_q && (32'(in_coeff_index) == 32'(nc_cl) - 32'd1);
  assign ref_wa   = AW'(in_entry_index) * AW'(MAX_COEFFS) + AW'(in_coeff_index);
  assign q_wa     = CW'(in_coeff_index);

  assign rd_addr  = row_r + AW'(c_r);
  assign c_last   = (NC_W'(c_r) == nc_cl - NC_W'(1));
  assign e_last   = (NE_W'(e_r) == ne_cl - NE_W'(1));

  always_ff @(posedge clk) begin
    if (wr_ref) ref_mem[ref_wa] <= in_coeff_value;
    ref_rd_r <= ref_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_q) q_mem[q_wa] <= in_coeff_value;
    q_rd_r <= q_mem[c_r];
  end

  // Scan pipeline: read, square, accumulate, compare
  assign diff    = (COEFF_BITS+1)'(q_rd_r) - (COEFF_BITS+1)'(ref_rd_r);
  assign sq_full = diff * diff;
  assign acc_sum = (DIST_W+1)'(acc_r) + (DIST_W+1)'(sq_r);

  always_comb begin
    if (s2_first_r) acc_nxt = DIST_W'(sq_r);
    else if (acc_sum[DIST_W]) acc_nxt = DIST_MAX;
    else acc_nxt = acc_sum[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= (state_r == ST_SCAN);
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (c_r == '0);
    s1_last_r  <= c_last;
    s1_fin_r   <= c_last && e_last;
    s1_ent_r   <= e_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_fin_r   <= s1_fin_r;
    s2_ent_r   <= s1_ent_r;
    sq_r       <= SQ_W'(sq_full);
    s3_last_r  <= s2_last_r;
    s3_fin_r   <= s2_fin_r;
    s3_ent_r   <= s2_ent_r;
    if (s2_vld_r) acc_r <= acc_nxt;
    if (s3_vld_r && s3_last_r && (s3_ent_r == '0 || acc_r < best_r)) begin
      best_r     <= acc_r;
      best_idx_r <= s3_ent_r;
    end
  end

  // Bit-serial divide and square root
  assign div_cand  = {rem_r, dq_r[DQ_W-1]};
  assign div_ge    = (div_cand >= {1'b0, den_r});
  assign sq_cand   = {srem_r, dq_r[DQ_W-1 -: 2]};
  assign sq_trial  = (SR_W+2)'({root_r, 2'b01});
  assign sq_ge     = (sq_cand >= sq_trial);
  assign v_rnd     = (RT_W+1)'(root_r) + (RT_W+1)'(srem_r > SR_W'(root_r));
  assign conf_full = (RT_W+2)'(CONF_ONE) - (RT_W+2)'(v_rnd);
  assign out_load  = (state_r == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      if (c_last) begin
        c_r   <= '0;
        e_r   <= e_r + EW'(1);
        row_r <= row_r + AW'(MAX_COEFFS);
      end else begin
        c_r <= c_r + CW'(1);
      end
    end else begin
      c_r   <= '0;
      e_r   <= '0;
      row_r <= '0;
    end
    unique case (state_r)
      ST_LOAD: begin
        dq_r  <= {best_r, FRAC_BITS'(0)};
        rem_r <= '0;
        cnt_r <= CNT_W'(DQ_W - 1);
      end
      ST_DIV: begin
        rem_r <= div_ge ? DEN_W'(div_cand - {1'b0, den_r}) : DEN_W'(div_cand);
        dq_r  <= {dq_r[DQ_W-2:0], div_ge};
        if (cnt_r == '0) begin
          cnt_r  <= CNT_W'(RT_W - 1);
          root_r <= '0;
          srem_r <= '0;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      ST_SQRT: begin
        srem_r <= sq_ge ? SR_W'(sq_cand - sq_trial) : SR_W'(sq_cand);
        root_r <= {root_r[RT_W-2:0], sq_ge};
        dq_r   <= {dq_r[DQ_W-3:0], 2'b00};
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE:  if (start) state_r <= ST_SCAN;
        ST_SCAN:  if (c_last && e_last) state_r <= ST_DRAIN;
        ST_DRAIN: if (s3_vld_r && s3_fin_r) state_r <= ST_LOAD;
        ST_LOAD:  state_r <= ST_DIV;
        ST_DIV:   if (cnt_r == '0) state_r <= ST_SQRT;
        ST_SQRT:  if (cnt_r == '0) state_r <= ST_DONE;
        ST_DONE:  if (out_load) state_r <= ST_IDLE;
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_nearest_index  <= IDX_W'(best_idx_r);
      out_least_distance <= best_r;
      out_confidence_q16 <= $signed(conf_full[CONF_W-1:0]);
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside the done state");

  a_scan_tags: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("scan pipeline active outside the search");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < den_r))
    else $error("divider remainder not below denominator");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT) |-> (srem_r <= SR_W'({root_r, 1'b0})))
    else $error("square root remainder out of bound");

endmodule

`default_nettype wire

// ----- dv/nearest_neighbour_search_unit_chk.sv -----
// Checker for the nearest neighbor search unit: tracks stores, predicts searches, compares.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbour_search_unit_chk #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_COEFFS  = 64
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  input  wire                                  in_ready,
  input  wire                                  in_opcode,
  input  wire [nns_pkg::IDX_W-1:0]             in_entry_index,
  input  wire [nns_pkg::IDX_W-1:0]             in_coeff_index,
  input  wire signed [nns_pkg::COEFF_BITS-1:0] in_coeff_value,
  input  wire                                  out_valid,
  input  wire                                  out_ready,
  input  wire [nns_pkg::IDX_W-1:0]             out_nearest_index,
  input  wire [nns_pkg::DIST_W-1:0]            out_least_distance,
  input  wire signed [nns_pkg::CONF_W-1:0]     out_confidence_q16,
  input  wire                                  cfg_we,
  input  wire [nns_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [nns_pkg::CFG_W-1:0]             cfg_wdata,
  output int                                   mismatch_count,
  output int                                   pending_results
);
  import nns_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]         index;
    logic [DIST_W-1:0]        distance;
    logic signed [CONF_W-1:0] confidence;
  } match_t;

  logic signed [COEFF_BITS-1:0] ref_vectors [MAX_ENTRIES][MAX_COEFFS];
  logic signed [COEFF_BITS-1:0] query_coeffs [MAX_COEFFS];
  logic [CFG_W-1:0]             entries_reg = 7'd64;
  logic [CFG_W-1:0]             coeffs_reg  = 7'd64;
  match_t                       awaited_matches [$];
  int                           results_seen = 0;

  function automatic int active_count(logic [CFG_W-1:0] v, int ceiling);
    if (v == 0) return 1;
    if (v > ceiling) return ceiling;
    return int'(v);
  endfunction

  // integer square root, rounded to nearest with halves up
  function automatic logic [47:0] rounded_root(logic [127:0] a);
    logic [47:0] r;
    logic [47:0] t;
    int          b;
    r = '0;
    for (b = 47; b >= 0; b--) begin
      t = r | (48'd1 << b);
      if (128'(t) * 128'(t) <= a) r = t;
    end
    if (a - 128'(r) * 128'(r) > 128'(r)) r = r + 1'b1;
    return r;
  endfunction

  function automatic match_t nearest_match();
    int              ne;
    int              nc;
    int              e;
    int              c;
    int              best_e;
    longint          d;
    longint unsigned sum;
    longint unsigned best;
    logic [127:0]    den;
    logic [127:0]    scaled;
    logic [127:0]    root;
    match_t          m;
    ne = active_count(entries_reg, MAX_ENTRIES);
    nc = active_count(coeffs_reg, MAX_COEFFS);
    best = DIST_MAX;
    best_e = 0;
    for (e = 0; e < ne; e++) begin
      sum = 0;
      for (c = 0; c < nc; c++) begin
        d = longint'(query_coeffs[c]) - longint'(ref_vectors[e][c]);
        sum += d * d;
        if (sum > DIST_MAX) sum = DIST_MAX;
      end
      if (e == 0 || sum < best) begin
        best = sum;
        best_e = e;
      end
    end
    den = 128'(ne) * 128'(nc) * 128'(DEN_K);
    scaled = (128'(best) << FRAC_BITS) / den;
    root = 128'(rounded_root(scaled));
    m.index = IDX_W'(best_e);
    m.distance = best[DIST_W-1:0];
    m.confidence = CONF_W'(128'(CONF_ONE) - root);
    return m;
  endfunction

  task automatic log_mismatch(bit unexpected, match_t want, match_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (unexpected)
        $display("%0t: result %0d with nothing awaited: index %0d distance %0d confidence %0d",
                 $time, results_seen, got.index, got.distance, $signed(got.confidence));
      else
        $display("%0t: result %0d: idx exp %0d got %0d, dist exp %0d got %0d, conf exp %0d got %0d",
                 $time, results_seen, want.index, got.index, want.distance, got.distance,
                 $signed(want.confidence), $signed(got.confidence));
    end
  endtask

  always @(posedge clk) begin
    match_t got;
    match_t want;
    if (!rst_n) begin
      entries_reg = 7'd64;
      coeffs_reg = 7'd64;
      mismatch_count = 0;
      awaited_matches.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ENTRIES) entries_reg = cfg_wdata;
        else if (cfg_index == CFG_COEFFS) coeffs_reg = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        got.index = out_nearest_index;
        got.distance = out_least_distance;
        got.confidence = out_confidence_q16;
        if (awaited_matches.size() == 0) begin
          log_mismatch(1'b1, got, got);
        end else begin
          want = awaited_matches.pop_front();
          if (got.index != want.index || got.distance != want.distance ||
              got.confidence != want.confidence)
            log_mismatch(1'b0, want, got);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        if (in_opcode == OP_REF) begin
          if (in_entry_index < MAX_ENTRIES && in_coeff_index < MAX_COEFFS)
            ref_vectors[in_entry_index][in_coeff_index] = in_coeff_value;
        end else if (in_coeff_index < MAX_COEFFS) begin
          query_coeffs[in_coeff_index] = in_coeff_value;
          // last query coefficient in use starts a search
          if (int'(in_coeff_index) == active_count(coeffs_reg, MAX_COEFFS) - 1)
            awaited_matches.insert(awaited_matches.size(), nearest_match());
        end
      end
    end
    pending_results = awaited_matches.size();
  end

endmodule

`default_nettype wire

// ----- dv/nearest_neighbour_search_unit_tb.sv -----
// Testbench top for the nearest neighbor search unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbour_search_unit_tb;
  import nns_pkg::*;

  localparam int MAX_ENTRIES  = 64;
  localparam int MAX_COEFFS   = 64;
  localparam int MAX_GAP      = 18;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = MAX_ENTRIES * MAX_COEFFS + 200;
  localparam int CYCLE_LIMIT  = 5_000_000;

  localparam int VAL_FULL = 0;
  localparam int VAL_TINY = 1;
  localparam int VAL_EDGE = 2;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_opcode;
  logic [IDX_W-1:0]             in_entry_index;
  logic [IDX_W-1:0]             in_coeff_index;
  logic signed [COEFF_BITS-1:0] in_coeff_value;
  logic                         out_valid;
  logic                         out_ready;
  logic [IDX_W-1:0]             out_nearest_index;
  logic [DIST_W-1:0]            out_least_distance;
  logic signed [CONF_W-1:0]     out_confidence_q16;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]             cfg_wdata;
  int                           mismatch_count;
  int                           pending_results;

  int cycle_count   = 0;
  int words_sent    = 0;
  int results_taken = 0;
  int send_burst    = 0;
  int recv_burst    = 0;
  int cur_entries   = 64;
  int cur_coeffs    = 64;
  bit ref_written [MAX_ENTRIES][MAX_COEFFS];
  bit query_written [MAX_COEFFS];

  nearest_neighbour_search_unit #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_COEFFS (MAX_COEFFS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_coeff_index    (in_coeff_index),
    .in_coeff_value    (in_coeff_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_nearest_index (out_nearest_index),
    .out_least_distance(out_least_distance),
    .out_confidence_q16(out_confidence_q16),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  nearest_neighbour_search_unit_chk #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_COEFFS (MAX_COEFFS)
  ) chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_coeff_index    (in_coeff_index),
    .in_coeff_value    (in_coeff_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_nearest_index (out_nearest_index),
    .out_least_distance(out_least_distance),
    .out_confidence_q16(out_confidence_q16),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (mismatch_count),
    .pending_results   (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nearest_neighbour_search_unit_tb: FAIL");
      $finish;
    end
  end

  // zero-gap runs now and then
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic int in_use(int v, int ceiling);
    return (v == 0) ? 1 : (v > ceiling) ? ceiling : v;
  endfunction

  function automatic logic [COEFF_BITS-1:0] pick_value(int mode);
    case (mode)
      VAL_TINY: return COEFF_BITS'($urandom_range(0, 4) - 2);
      VAL_EDGE: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return COEFF_BITS'($urandom);
    endcase
  endfunction

  task automatic put_word(logic op, int entry, int coeff, logic [COEFF_BITS-1:0] value);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_opcode      = op;
    in_entry_index = IDX_W'(entry);
    in_coeff_index = IDX_W'(coeff);
    in_coeff_value = value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op == OP_REF) ref_written[entry][coeff] = 1'b1;
    else query_written[coeff] = 1'b1;
    words_sent++;
  endtask

  // registers change only with the block idle
  task automatic set_regs(int entries_val, int coeffs_val);
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_ENTRIES;
    cfg_wdata = CFG_W'(entries_val);
    @(negedge clk);
    cfg_index = CFG_COEFFS;
    cfg_wdata = CFG_W'(coeffs_val);
    @(negedge clk);
    cfg_we = 1'b0;
    cur_entries = in_use(entries_val, MAX_ENTRIES);
    cur_coeffs = in_use(coeffs_val, MAX_COEFFS);
  endtask

  // write every slot a search will read; polar also runs the max-distance search
  task automatic fill_needed(bit polar);
    int e;
    int c;
    int last;
    for (e = 0; e < cur_entries; e++)
      for (c = 0; c < cur_coeffs; c++)
        if (polar || !ref_written[e][c])
          put_word(OP_REF, e, c, polar ? 16'h7FFF : pick_value(VAL_FULL));
    last = polar ? cur_coeffs : cur_coeffs - 1;
    for (c = 0; c < last; c++)
      if (polar || !query_written[c])
        put_word(OP_QUERY, $urandom_range(0, MAX_ENTRIES - 1), c,
                 polar ? 16'h8000 : pick_value(VAL_FULL));
  endtask

  task automatic stray_ref(int mode);
    int e;
    int c;
    e = ($urandom_range(0, 4) != 0) ? $urandom_range(0, cur_entries - 1)
                                    : $urandom_range(0, MAX_ENTRIES - 1);
    c = ($urandom_range(0, 4) != 0) ? $urandom_range(0, cur_coeffs - 1)
                                    : $urandom_range(0, MAX_COEFFS - 1);
    put_word(OP_REF, e, c, pick_value(mode));
  endtask

  // full query vector, sometimes cut short, with stray reference words mixed in
  task automatic query_run(int mode);
    int c;
    int stop;
    stop = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cur_coeffs - 1) : cur_coeffs;
    for (c = 0; c < stop; c++) begin
      if ($urandom_range(0, 7) == 0) stray_ref(mode);
      put_word(OP_QUERY, $urandom_range(0, MAX_ENTRIES - 1), c, pick_value(mode));
    end
  endtask

  task automatic run_phase(int entries_val, int coeffs_val, int word_budget, bit polar);
    int start;
    int mode;
    set_regs(entries_val, coeffs_val);
    fill_needed(polar);
    start = words_sent;
    while (words_sent - start < word_budget) begin
      mode = $urandom_range(VAL_FULL, VAL_EDGE);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: query_run(mode);
        12, 13, 14, 15, 16: stray_ref(mode);
        default: put_word(OP_QUERY, $urandom_range(0, MAX_ENTRIES - 1),
                          $urandom_range(0, MAX_COEFFS - 1), pick_value(mode));
      endcase
    end
  endtask

  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(recv_burst);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
      @(negedge clk);
      // long hold-off so the block backs up onto its input
      if (results_taken % 50 == 10) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_REF;
    in_entry_index = '0;
    in_coeff_index = '0;
    in_coeff_value = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ENTRIES;
    cfg_wdata      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // three entries of two coefficients; entries 1 and 2 tie
    set_regs(3, 2);
    put_word(OP_REF, 0, 0, 16'h7FFF);
    put_word(OP_REF, 0, 1, 16'h8000);
    put_word(OP_REF, 1, 0, 16'h0000);
    put_word(OP_REF, 1, 1, 16'h0000);
    put_word(OP_REF, 2, 0, 16'h0000);
    put_word(OP_REF, 2, 1, 16'h0000);
    put_word(OP_REF, 63, 63, 16'hFFFF);
    put_word(OP_QUERY, 63, 63, 16'h5555);
    put_word(OP_QUERY, 0, 0, 16'h8000);
    put_word(OP_QUERY, 63, 1, 16'h7FFF);
    put_word(OP_QUERY, 0, 1, 16'h0000);
    put_word(OP_QUERY, 21, 0, 16'h0000);
    put_word(OP_QUERY, 42, 1, 16'h0000);
    put_word(OP_QUERY, 0, 0, 16'h7FFF);
    put_word(OP_QUERY, 63, 1, 16'h8000);

    run_phase(0, 127, 100, 1'b1);
    run_phase(127, 0, 130, 1'b0);
    run_phase(64, 3, 130, 1'b0);
    run_phase(2, 64, 130, 1'b0);
    run_phase(4, 8, 160, 1'b0);
    run_phase(7, 5, 160, 1'b0);
    run_phase(1, 1, 70, 1'b0);
    repeat (2) run_phase($urandom_range(1, 16), $urandom_range(1, 16), 100, 1'b0);

    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0)
      $display("nearest_neighbour_search_unit_tb: PASS");
    else
      $display("nearest_neighbour_search_unit_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
